[rtl/cpu_pkg.sv]
// ---------------------------------------------------------------------------
// cpu_pkg: shared types and helpers for the cantor pair / unpair pipeline
// Holds the mode code, the per-stage beat record and the square root step.
// ---------------------------------------------------------------------------
package cpu_pkg;

   localparam int CODE_BITS  = 31;
   localparam int HALF_BITS  = 16;
   localparam int IN_BITS    = 15;
   localparam int RAD_BITS   = CODE_BITS + 3;       // 8z+1
   localparam int ROOT_BITS  = (RAD_BITS + 1) / 2;  // one root bit per radicand pair
   localparam int REM_BITS   = ROOT_BITS + 3;
   localparam int PROD_BITS  = 2 * HALF_BITS;

   typedef enum logic {
      MODE_PAIR   = 1'b0,
      MODE_UNPAIR = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type               mode;
      logic [HALF_BITS-1:0]   sum;      // x + y
      logic [IN_BITS-1:0]     y;
      logic [CODE_BITS-1:0]   z;
      logic [RAD_BITS-1:0]    rad;      // radicand, consumed two bits per step
      logic [REM_BITS-1:0]    rem;
      logic [ROOT_BITS-1:0]   root;
      logic [HALF_BITS-1:0]   n;
      logic [PROD_BITS-1:0]   prod;
      logic [CODE_BITS-1:0]   code;
      logic [HALF_BITS-1:0]   first;
      logic [HALF_BITS-1:0]   second;
   } stage_type;

   // one digit of the restoring square root
   function automatic stage_type root_step(input stage_type s);
      stage_type           o;
      logic [REM_BITS+1:0] cur;
      logic [REM_BITS+1:0] trial;
      o     = s;
      cur   = {s.rem, s.rad[RAD_BITS-1 -: 2]};
      trial = {{(REM_BITS-ROOT_BITS){1'b0}}, s.root, 2'b01};
      o.rad = {s.rad[RAD_BITS-3:0], 2'b00};
      if (cur >= trial) begin
         o.rem  = REM_BITS'(cur - trial);
         o.root = {s.root[ROOT_BITS-2:0], 1'b1};
      end else begin
         o.rem  = cur[REM_BITS-1:0];
         o.root = {s.root[ROOT_BITS-2:0], 1'b0};
      end
      return o;
   endfunction

endpackage

[rtl/cpu_stage.sv]
// ---------------------------------------------------------------------------
// cpu_stage: one pipeline slot
// Holds a beat and its valid bit; fills whenever empty or draining so that
// bubbles close up behind a stalled output.
// ---------------------------------------------------------------------------
module cpu_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   input  cpu_pkg::stage_type up_data,
   output logic               up_ready,
   output logic               down_valid,
   output cpu_pkg::stage_type down_data,
   input  logic               down_ready
);

   logic               valid_ff;
   cpu_pkg::stage_type data_ff;

   assign up_ready   = !valid_ff || down_ready;
   assign down_valid = valid_ff;
   assign down_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= up_data;
      end
   end

endmodule

[rtl/cantor_pair_unpair.sv]
// ---------------------------------------------------------------------------
// cantor_pair_unpair: Cantor pairing and unpairing, one beat per cycle unless stalled
// Pair mode folds two coordinates into a code, unpair mode splits a code.
// ---------------------------------------------------------------------------
// Usage
//   req_ channel carries req_mode (0 pair, 1 unpair), req_coord_a/b for pair
//   mode and req_code_in for unpair mode. A beat is taken when req_valid is
//   high and req_stall low. rsp_ returns exactly one beat per request, in
//   order: rsp_code_out in pair mode, rsp_first_out/rsp_second_out in unpair
//   mode, unused fields zero.
//   A beat passes through one input stage, 17 square root stages (one root
//   bit each), one shared 16x17 multiply stage and one output stage.
//   Throughput is one beat per cycle while the receiver does not stall; every
//   stage takes a new beat in each cycle in which it has room.
//   When the receiver stalls, the output holds and beats close up behind it;
//   req_stall only rises once every stage is full.
//   Synchronous reset empties all stages; payload registers are not cleared.
// ---------------------------------------------------------------------------
module cantor_pair_unpair #(
   parameter int COORD_BITS = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [14:0] req_coord_a,
   input  logic [14:0] req_coord_b,
   input  logic [30:0] req_code_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [30:0] rsp_code_out,
   output logic [15:0] rsp_first_out,
   output logic [15:0] rsp_second_out
);

   localparam int ROOT_STAGES = cpu_pkg::ROOT_BITS;
   localparam int MUL_STAGE   = ROOT_STAGES + 1;
   localparam int NUM_STAGES  = ROOT_STAGES + 3;

   logic               st_v   [NUM_STAGES];
   cpu_pkg::stage_type st_d   [NUM_STAGES];
   cpu_pkg::stage_type st_in  [NUM_STAGES];
   logic               st_rdy [NUM_STAGES+1];
   logic               up_v   [NUM_STAGES];

   assign st_rdy[NUM_STAGES] = !rsp_stall;
   assign req_stall          = !st_rdy[0];

   // input stage: mask coordinates, form x+y and the radicand 8z+1
   always_comb begin
      logic [cpu_pkg::IN_BITS-1:0] x;
      logic [cpu_pkg::IN_BITS-1:0] y;
      x             = cpu_pkg::IN_BITS'(req_coord_a[COORD_BITS-1:0]);
      y             = cpu_pkg::IN_BITS'(req_coord_b[COORD_BITS-1:0]);
      st_in[0]      = '0;
      st_in[0].mode = cpu_pkg::mode_type'(req_mode);
      st_in[0].y    = y;
      st_in[0].sum  = cpu_pkg::HALF_BITS'(x) + cpu_pkg::HALF_BITS'(y);
      st_in[0].z    = req_code_in;
      st_in[0].rad  = {req_code_in, 3'b001};
   end

   for (genvar i = 1; i <= ROOT_STAGES; i++) begin : g_root
      assign st_in[i] = cpu_pkg::root_step(st_d[i-1]);
   end

   // shared multiply: n(n+1) when unpairing, s(s+1) when pairing
   always_comb begin
      logic [cpu_pkg::ROOT_BITS-1:0] rm1;
      logic [cpu_pkg::HALF_BITS-1:0] a;
      logic [cpu_pkg::HALF_BITS:0]   a1;
      rm1                   = st_d[MUL_STAGE-1].root - cpu_pkg::ROOT_BITS'(1);
      st_in[MUL_STAGE]      = st_d[MUL_STAGE-1];
      st_in[MUL_STAGE].n    = rm1[cpu_pkg::ROOT_BITS-1:1];
      a = (st_d[MUL_STAGE-1].mode == cpu_pkg::MODE_UNPAIR) ?
          rm1[cpu_pkg::ROOT_BITS-1:1] : st_d[MUL_STAGE-1].sum;
      a1                    = {1'b0, a} + 17'd1;
      st_in[MUL_STAGE].prod = cpu_pkg::PROD_BITS'(a) * cpu_pkg::PROD_BITS'(a1);
   end

   // output stage
   always_comb begin
      logic [cpu_pkg::CODE_BITS-1:0] tri_num;
      logic [cpu_pkg::CODE_BITS-1:0] yy;
      cpu_pkg::stage_type            s;
      s       = st_d[NUM_STAGES-2];
      tri_num = s.prod[cpu_pkg::PROD_BITS-1:1];
      yy      = s.z - tri_num;
      st_in[NUM_STAGES-1] = s;
      if (s.mode == cpu_pkg::MODE_UNPAIR) begin
         st_in[NUM_STAGES-1].code   = '0;
         st_in[NUM_STAGES-1].second = yy[cpu_pkg::HALF_BITS-1:0];
         st_in[NUM_STAGES-1].first  = s.n - yy[cpu_pkg::HALF_BITS-1:0];
      end else begin
         st_in[NUM_STAGES-1].code   = tri_num + cpu_pkg::CODE_BITS'(s.y);
         st_in[NUM_STAGES-1].second = '0;
         st_in[NUM_STAGES-1].first  = '0;
      end
   end

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
      if (i == 0) begin : g_first
         assign up_v[i] = req_valid;
      end else begin : g_rest
         assign up_v[i] = st_v[i-1];
      end
      cpu_stage u_stage (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (up_v[i]),
         .up_data    (st_in[i]),
         .up_ready   (st_rdy[i]),
         .down_valid (st_v[i]),
         .down_data  (st_d[i]),
         .down_ready (st_rdy[i+1])
      );
   end

   assign rsp_valid      = st_v[NUM_STAGES-1];
   assign rsp_code_out   = st_d[NUM_STAGES-1].code;
   assign rsp_first_out  = st_d[NUM_STAGES-1].first;
   assign rsp_second_out = st_d[NUM_STAGES-1].second;

   // pair beats carry no coordinates back
   a_pair_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && st_d[NUM_STAGES-1].mode == cpu_pkg::MODE_PAIR |->
      rsp_first_out == '0 && rsp_second_out == '0)
      else $error("pair response with non-zero coordinates");

   // unpair beats carry no code, and y never exceeds n
   a_unpair_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && st_d[NUM_STAGES-1].mode == cpu_pkg::MODE_UNPAIR |->
      rsp_code_out == '0 && rsp_second_out <= st_d[NUM_STAGES-1].n)
      else $error("unpair response out of range");

   // input is held back only when the whole pipe is full behind a stall
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall && st_v[0] && st_v[MUL_STAGE])
      else $error("request stalled with room in the pipe");

   // nothing comes out straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// testbench: self-checking bench for cantor_pair_unpair
// Drives pair and unpair beats in random bursts against a receiver that
// stalls in changing patterns. Every request beat is predicted on acceptance
// and each response beat is checked field by field, in order.
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          COORD_BITS   = 15;
   localparam logic [63:0] COORD_MASK   = (64'd1 << COORD_BITS) - 64'd1;
   localparam logic [30:0] CODE_MAX     = 31'h7fff_ffff;
   localparam int          RANDOM_BEATS = 750;
   localparam int          IDLE_LIMIT   = 2000;
   localparam int          DRAIN_CYCLES = 40;    // pipeline is 20 deep

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   typedef struct {
      cpu_pkg::mode_type                 mode;
      logic [cpu_pkg::IN_BITS-1:0]       coord_a;
      logic [cpu_pkg::IN_BITS-1:0]       coord_b;
      logic [cpu_pkg::CODE_BITS-1:0]     code;
   } cantor_req_type;

   typedef struct {
      logic [cpu_pkg::CODE_BITS-1:0]     code;
      logic [cpu_pkg::HALF_BITS-1:0]     first;
      logic [cpu_pkg::HALF_BITS-1:0]     second;
   } cantor_rsp_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic        req_mode       = 1'b0;
   logic [14:0] req_coord_a    = '0;
   logic [14:0] req_coord_b    = '0;
   logic [30:0] req_code_in    = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [30:0] rsp_code_out;
   logic [15:0] rsp_first_out;
   logic [15:0] rsp_second_out;

   cantor_req_type pending_beats[$];
   cantor_rsp_type expected_codes[$];

   bit          req_taken      = 1'b0;
   bit          rsp_taken      = 1'b0;
   int          mismatches     = 0;
   int          idle_cycles    = 0;
   int          pair_beats     = 0;
   int          unpair_beats   = 0;
   int          checked_beats  = 0;

   cantor_pair_unpair #(
      .COORD_BITS (COORD_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_coord_a    (req_coord_a),
      .req_coord_b    (req_coord_b),
      .req_code_in    (req_code_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_out   (rsp_code_out),
      .rsp_first_out  (rsp_first_out),
      .rsp_second_out (rsp_second_out)
   );

   always #5 clock = ~clock;

   // exact pairing, and unpairing through a bitwise floor square root
   function automatic cantor_rsp_type cantor_predict(cantor_req_type r);
      cantor_rsp_type res;
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] s;
      logic [63:0] z;
      logic [63:0] rad;
      logic [63:0] root;
      logic [63:0] cand;
      logic [63:0] n;
      logic [63:0] tn;
      res = '{default: '0};
      if (r.mode == cpu_pkg::MODE_PAIR) begin
         x = 64'(r.coord_a) & COORD_MASK;
         y = 64'(r.coord_b) & COORD_MASK;
         s = x + y;
         z = (((s + 64'd1) * s) >> 1) + y;
         res.code = z[cpu_pkg::CODE_BITS-1:0];
      end else begin
         z    = 64'(r.code);
         rad  = 64'd8 * z + 64'd1;
         root = '0;
         for (int i = 17; i >= 0; i--) begin
            cand = root | (64'd1 << i);
            if (cand * cand <= rad) root = cand;
         end
         n  = (root - 64'd1) >> 1;
         tn = (n * (n + 64'd1)) >> 1;
         y  = z - tn;
         x  = n - y;
         res.first  = x[cpu_pkg::HALF_BITS-1:0];
         res.second = y[cpu_pkg::HALF_BITS-1:0];
      end
      return res;
   endfunction

   // unused fields carry random junk so that the block must ignore them
   task automatic add_pair(input logic [14:0] a, input logic [14:0] b);
      cantor_req_type r;
      r.mode    = cpu_pkg::MODE_PAIR;
      r.coord_a = a;
      r.coord_b = b;
      r.code    = 31'($urandom());
      pending_beats.push_back(r);
   endtask

   task automatic add_unpair(input logic [30:0] z);
      cantor_req_type r;
      r.mode    = cpu_pkg::MODE_UNPAIR;
      r.coord_a = 15'($urandom());
      r.coord_b = 15'($urandom());
      r.code    = z;
      pending_beats.push_back(r);
   endtask

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // sender: bursts of random length separated by random gaps
   int             burst_left = 20;
   int             gap_left   = 0;
   cantor_req_type next_beat;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            next_beat = pending_beats.pop_front();
            req_mode    <= next_beat.mode;
            req_coord_a <= next_beat.coord_a;
            req_coord_b <= next_beat.coord_b;
            req_code_in <= next_beat.code;
            req_valid   <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               // an occasional long gap lets the pipeline drain completely
               gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(0, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall style is redrawn whenever its random run ends
   stall_style_type stall_style = STALL_NONE;
   int              style_left  = 0;
   int              stall_phase = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (style_left == 0) begin
            stall_style = stall_style_type'($urandom_range(0, 3));
            style_left  = $urandom_range(50, 300);
         end else begin
            style_left--;
         end
         stall_phase = (stall_phase + 1) % 11;
         case (stall_style)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: rsp_stall <= (stall_phase < 7);
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   // sample both channels, predict on request beats, check response beats
   cantor_req_type seen_req;
   cantor_rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         req_taken   = 1'b0;
         rsp_taken   = 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken = req_valid && !req_stall;
         rsp_taken = rsp_valid && !rsp_stall;
         if (req_taken) begin
            seen_req.mode    = cpu_pkg::mode_type'(req_mode);
            seen_req.coord_a = req_coord_a;
            seen_req.coord_b = req_coord_b;
            seen_req.code    = req_code_in;
            expected_codes.push_back(cantor_predict(seen_req));
            if (seen_req.mode == cpu_pkg::MODE_PAIR) pair_beats++;
            else unpair_beats++;
         end
         if (rsp_taken) begin
            if (expected_codes.size() == 0) begin
               flag_mismatch("unexpected response beat, code_out",
                             64'(rsp_code_out), 64'd0);
            end else begin
               want = expected_codes.pop_front();
               checked_beats++;
               if (rsp_code_out !== want.code)
                  flag_mismatch("code_out", 64'(rsp_code_out), 64'(want.code));
               if (rsp_first_out !== want.first)
                  flag_mismatch("first_out", 64'(rsp_first_out), 64'(want.first));
               if (rsp_second_out !== want.second)
                  flag_mismatch("second_out", 64'(rsp_second_out),
                                64'(want.second));
            end
         end
         if (req_taken || rsp_taken) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      int          sel;
      logic [63:0] n;
      logic [63:0] tn;
      logic [63:0] z;

      // corners of both modes
      add_pair(15'd0, 15'd0);
      add_pair(15'h7fff, 15'h7fff);
      add_pair(15'h7fff, 15'd0);
      add_pair(15'd0, 15'h7fff);
      add_pair(15'd1, 15'd0);
      add_pair(15'd0, 15'd1);
      add_pair(15'h5555, 15'h2aaa);
      add_unpair(31'd0);
      add_unpair(31'd1);
      add_unpair(31'd2);
      add_unpair(31'd3);
      add_unpair(CODE_MAX);
      add_unpair(31'd2147418112);   // largest code that pair mode can make
      add_unpair(31'd2147450880);   // start of the last diagonal
      add_unpair(31'd2147450879);   // end of the one below it
      add_unpair(31'd2147385345);
      add_unpair(31'h5555_5555);
      add_unpair(31'h2aaa_aaaa);

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         sel = $urandom_range(0, 9);
         if (sel <= 3) begin
            if ($urandom_range(0, 3) == 0)
               add_pair(15'($urandom_range(0, 15)), 15'($urandom_range(0, 15)));
            else
               add_pair(15'($urandom()), 15'($urandom()));
         end else if (sel <= 6) begin
            add_unpair(31'($urandom()));
         end else if (sel <= 8) begin
            // codes at the start or end of a diagonal, or anywhere inside one
            n  = 64'($urandom_range(0, 65535));
            tn = (n * (n + 64'd1)) >> 1;
            case ($urandom_range(0, 2))
               0:       z = tn;
               1:       z = tn + n;
               default: z = tn + 64'($urandom_range(0, n[31:0]));
            endcase
            if (z > 64'(CODE_MAX)) z = tn;
            add_unpair(z[30:0]);
         end else begin
            add_unpair(31'($urandom_range(0, 300)));
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_beats.size() > 0 || req_valid) @(posedge clock);
      while (expected_codes.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d pair and %0d unpair beats, %0d responses checked",
               pair_beats, unpair_beats, checked_beats);
      $display("receiver stalled in none, light, heavy and periodic styles");
      if (mismatches == 0 && expected_codes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
